// ===== hw/rtl/wsfb_pkg.sv =====
`timescale 1ns / 1ps

package wsfb_pkg;

  localparam int HDR_MAX = 14;
  localparam int HDR_CNT_W = 4;

  localparam logic [HDR_CNT_W-1:0] HDR_LEN_SHORT = 4'd6;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_MID   = 4'd8;
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_LONG  = 4'd14;

  localparam logic [7:0] LEN16_CODE = 8'd126;
  localparam logic [7:0] LEN64_CODE = 8'd127;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;
  localparam logic [7:0] FLAG_BIT   = 8'h80;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef logic [7:0] byte_t;

endpackage

// ===== hw/rtl/websocket_frame_builder.sv =====
`timescale 1ns / 1ps
// A payload word appears on the output in the cycle after it is accepted.
// A start word fills a header buffer; its 6, 8 or 14 header words follow one per
// cycle while the output is not stalled, and the input stalls until the buffer drains.
// Payload words are taken one per cycle while the output is not stalled.
// Reset: synchronous active-low rst_n clears frame state and empties all stages.
module websocket_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [63:0] in_frame_length,
  input  logic [3:0]  in_frame_kind,
  input  logic [31:0] in_mask_key,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_frame_end
);

  wsfb_pkg::byte_t                     hdr_r   [wsfb_pkg::HDR_MAX];
  wsfb_pkg::byte_t                     hdr_nxt [wsfb_pkg::HDR_MAX];
  logic [wsfb_pkg::HDR_CNT_W-1:0]      hdr_cnt_r, hdr_cnt_nxt;
  logic                                hdr_end_r, hdr_end_nxt;

  logic [63:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        frame_open_r, frame_open_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_end_r, out_end_nxt;

  logic        out_free;
  logic        in_acc;
  logic        is_start;
  logic        hdr_busy;
  logic [1:0]  key_sel;
  logic [7:0]  key_byte;

  assign hdr_busy = (hdr_cnt_r != '0);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = hdr_busy || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign is_start = (in_opcode == wsfb_pkg::OP_START);
  assign key_sel  = 2'd3 - phase_r;
  assign key_byte = key_r[{key_sel, 3'b000} +: 8];

  always_comb begin
    hdr_nxt        = hdr_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    hdr_end_nxt    = hdr_end_r;
    bytes_left_nxt = bytes_left_r;
    key_nxt        = key_r;
    phase_nxt      = phase_r;
    frame_open_nxt = frame_open_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_end_nxt    = out_end_r;

    if (in_acc && is_start) begin
      for (int i = 0; i < wsfb_pkg::HDR_MAX; i++) hdr_nxt[i] = '0;
      hdr_nxt[0] = wsfb_pkg::FLAG_BIT | {4'b0000, in_frame_kind};
      if (in_frame_length < {56'd0, wsfb_pkg::LEN16_CODE}) begin
        hdr_nxt[1] = wsfb_pkg::FLAG_BIT | {1'b0, in_frame_length[6:0]};
        for (int k = 0; k < 4; k++) hdr_nxt[2 + k] = in_mask_key[31 - 8*k -: 8];
        hdr_cnt_nxt = wsfb_pkg::HDR_LEN_SHORT;
      end else if (in_frame_length[63:16] == '0) begin
        hdr_nxt[1] = wsfb_pkg::FLAG_BIT | wsfb_pkg::LEN16_CODE;
        hdr_nxt[2] = in_frame_length[15:8];
        hdr_nxt[3] = in_frame_length[7:0];
        for (int k = 0; k < 4; k++) hdr_nxt[4 + k] = in_mask_key[31 - 8*k -: 8];
        hdr_cnt_nxt = wsfb_pkg::HDR_LEN_MID;
      end else begin
        hdr_nxt[1] = wsfb_pkg::FLAG_BIT | wsfb_pkg::LEN64_CODE;
        for (int k = 0; k < 8; k++) hdr_nxt[2 + k] = in_frame_length[63 - 8*k -: 8];
        for (int k = 0; k < 4; k++) hdr_nxt[10 + k] = in_mask_key[31 - 8*k -: 8];
        hdr_cnt_nxt = wsfb_pkg::HDR_LEN_LONG;
      end
      hdr_end_nxt    = (in_frame_length == '0);
      key_nxt        = in_mask_key;
      phase_nxt      = '0;
      bytes_left_nxt = in_frame_length;
      frame_open_nxt = (in_frame_length != '0);
    end else if (out_free && hdr_busy) begin
      for (int i = 0; i < wsfb_pkg::HDR_MAX - 1; i++) hdr_nxt[i] = hdr_r[i + 1];
      hdr_cnt_nxt = hdr_cnt_r - 1'b1;
    end

    if (out_free) begin
      if (hdr_busy) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = hdr_r[0];
        out_end_nxt   = hdr_end_r && (hdr_cnt_r == {{(wsfb_pkg::HDR_CNT_W-1){1'b0}}, 1'b1});
      end else if (in_acc && !is_start && frame_open_r) begin
        out_valid_nxt  = 1'b1;
        out_byte_nxt   = (in_data_byte ^ key_byte) & wsfb_pkg::BYTE_MASK;
        out_end_nxt    = (bytes_left_r == 64'd1);
        bytes_left_nxt = bytes_left_r - 64'd1;
        phase_nxt      = phase_r + 2'd1;
        if (bytes_left_r == 64'd1) begin
          frame_open_nxt = 1'b0;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r    <= '0;
      hdr_end_r    <= 1'b0;
      bytes_left_r <= '0;
      key_r        <= '0;
      phase_r      <= '0;
      frame_open_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hdr_cnt_r    <= hdr_cnt_nxt;
      hdr_end_r    <= hdr_end_nxt;
      bytes_left_r <= bytes_left_nxt;
      key_r        <= key_nxt;
      phase_r      <= phase_nxt;
      frame_open_r <= frame_open_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    hdr_r      <= hdr_nxt;
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_end_r;

`ifndef SYNTHESIS
  a_hdr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_busy |-> in_stall)
    else $error("input taken while header drains");

  a_closed_frame_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !frame_open_r |-> (bytes_left_r == '0))
    else $error("closed frame still counts payload");

  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r <= wsfb_pkg::HDR_LEN_LONG)
    else $error("header count out of range");

  a_empty_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_start && (in_frame_length == '0)) |=> (!frame_open_r && hdr_end_r))
    else $error("empty frame left open");
`endif

endmodule

// ===== tb/frame_checker.sv =====
`timescale 1ns / 1ps

module frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_opcode,
  input  logic [63:0] in_frame_length,
  input  logic [3:0]  in_frame_kind,
  input  logic [31:0] in_mask_key,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_frame_end,
  output int          mismatch_count,
  output int          pending_words,
  output int          checked_words
);

  typedef struct packed {
    wsfb_pkg::byte_t value;
    logic            is_last;
  } wire_word_t;

  wire_word_t  wire_q[$];
  logic [63:0] remaining  = '0;
  logic [31:0] frame_key  = '0;
  logic [1:0]  key_idx    = '0;
  logic        in_frame   = 1'b0;
  int          fail_total = 0;
  int          word_total = 0;

  function automatic wsfb_pkg::byte_t key_lane(input logic [31:0] key, input logic [1:0] idx);
    return key[8 * (3 - idx) +: 8];
  endfunction

  task automatic push_word(input wsfb_pkg::byte_t value, input logic is_last);
    wire_q.push_back('{value: value, is_last: is_last});
  endtask

  task automatic encode_word(input logic op, input logic [63:0] len, input logic [3:0] kind,
                             input logic [31:0] key, input wsfb_pkg::byte_t data);
    int i;
    if (op == wsfb_pkg::OP_START) begin
      push_word(wsfb_pkg::FLAG_BIT | {4'h0, kind}, 1'b0);
      if (len < 64'd126) begin
        push_word(wsfb_pkg::FLAG_BIT | len[7:0], 1'b0);
      end else if (len <= 64'hFFFF) begin
        push_word(wsfb_pkg::FLAG_BIT | wsfb_pkg::LEN16_CODE, 1'b0);
        push_word(len[15:8], 1'b0);
        push_word(len[7:0], 1'b0);
      end else begin
        push_word(wsfb_pkg::FLAG_BIT | wsfb_pkg::LEN64_CODE, 1'b0);
        for (i = 7; i >= 0; i--) push_word(len[8 * i +: 8], 1'b0);
      end
      for (i = 0; i < 4; i++) push_word(key_lane(key, i[1:0]), (i == 3) && (len == 64'd0));
      frame_key = key;
      key_idx   = 2'd0;
      remaining = len;
      in_frame  = (len != 64'd0);
    end else if (in_frame) begin
      remaining = remaining - 64'd1;
      push_word(data ^ key_lane(frame_key, key_idx), remaining == 64'd0);
      key_idx = key_idx + 2'd1;
      if (remaining == 64'd0) in_frame = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    wire_word_t want;
    if (!rst_n) begin
      wire_q.delete();
      remaining = '0;
      frame_key = '0;
      key_idx   = '0;
      in_frame  = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        word_total++;
        if (wire_q.size() == 0) begin
          if (fail_total < 10)
            $display("unexpected output word: expected none, got %02h end %b",
                     out_byte, out_frame_end);
          fail_total++;
        end else begin
          want = wire_q.pop_front();
          if (out_byte !== want.value || out_frame_end !== want.is_last) begin
            if (fail_total < 10)
              $display("mismatch on word %0d: expected %02h end %b, got %02h end %b",
                       word_total, want.value, want.is_last, out_byte, out_frame_end);
            fail_total++;
          end
        end
      end
      if (in_valid && !in_stall)
        encode_word(in_opcode, in_frame_length, in_frame_kind, in_mask_key, in_data_byte);
    end
    mismatch_count <= fail_total;
    pending_words  <= wire_q.size();
    checked_words  <= word_total;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_LEN    = 200;
  localparam int DRAIN       = 20;
  localparam int PHASE_ITEMS = 85;

  typedef enum logic [2:0] {
    PH_CALM,
    PH_TX_GAPS,
    PH_RX_STALL,
    PH_BOTH,
    PH_PRESSURE
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [63:0] in_frame_length;
  logic [3:0]  in_frame_kind;
  logic [31:0] in_mask_key;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_frame_end;

  int     mismatch_count;
  int     pending_words;
  int     checked_words;
  phase_t phase        = PH_CALM;
  int     rx_stall_pct = 0;
  int     tx_gap_pct   = 0;
  int     hold_cnt     = 0;
  int     frames_sent  = 0;
  int     data_sent    = 0;
  int     live_items   = 0;

  always #2 clk = ~clk;

  websocket_frame_builder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_frame_length(in_frame_length),
    .in_frame_kind  (in_frame_kind),
    .in_mask_key    (in_mask_key),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_frame_end  (out_frame_end)
  );

  frame_checker frame_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_frame_length(in_frame_length),
    .in_frame_kind  (in_frame_kind),
    .in_mask_key    (in_mask_key),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_frame_end  (out_frame_end),
    .mismatch_count (mismatch_count),
    .pending_words  (pending_words),
    .checked_words  (checked_words)
  );

  // hold off the output for a long stretch once the pressure phase begins
  always @(posedge clk) begin
    if (phase == PH_PRESSURE && hold_cnt < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("no word moved for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input wsfb_pkg::op_t op, input logic [63:0] len,
                           input logic [3:0] kind, input logic [31:0] key,
                           input wsfb_pkg::byte_t data);
    while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_frame_length <= len;
    in_frame_kind   <= kind;
    in_mask_key     <= key;
    in_data_byte    <= data;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_start(input logic [63:0] len, input logic [3:0] kind,
                            input logic [31:0] key);
    send_word(wsfb_pkg::OP_START, len, kind, key, wsfb_pkg::byte_t'($urandom));
    frames_sent++;
    live_items++;
  endtask

  task automatic send_data(input wsfb_pkg::byte_t data, input bit counted);
    send_word(wsfb_pkg::OP_DATA, rand64(), 4'($urandom), $urandom, data);
    data_sent++;
    if (counted) live_items++;
  endtask

  task automatic run_frame();
    logic [63:0] len;
    int          cls;
    int          count;
    cls = $urandom_range(99);
    if (cls < 70) begin
      len = 64'($urandom_range(12));
    end else if (cls < 85) begin
      len = 64'($urandom_range(65535, 126));
    end else begin
      len = rand64();
      if (len <= 64'hFFFF) len[40] = 1'b1;
    end
    send_start(len, 4'($urandom), $urandom);
    if (len <= 64'd12)
      count = ($urandom_range(9) == 0) ? int'($urandom_range(32'(len))) : int'(len);
    else count = $urandom_range(10);
    for (int i = 0; i < count; i++) send_data(wsfb_pkg::byte_t'($urandom), 1'b1);
    // drop a stray word now and then once the frame is closed
    if (count == len && $urandom_range(99) < 8)
      send_data(wsfb_pkg::byte_t'($urandom), 1'b0);
  endtask

  task automatic run_phase(input phase_t p, input int tx_pct, input int rx_pct);
    int stop_at;
    phase        <= p;
    rx_stall_pct <= rx_pct;
    tx_gap_pct   = tx_pct;
    stop_at      = live_items + PHASE_ITEMS;
    while (live_items < stop_at) run_frame();
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= wsfb_pkg::OP_DATA;
    in_frame_length <= '0;
    in_frame_kind   <= '0;
    in_mask_key     <= '0;
    in_data_byte    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_data(8'h00, 1'b0);
    send_data(8'hFF, 1'b0);
    send_start(64'd0, 4'h0, 32'h0000_0000);
    send_start(64'd0, 4'hF, 32'hFFFF_FFFF);
    send_start(64'd1, 4'h1, 32'h1234_5678);
    send_data(8'hFF, 1'b1);
    send_start(64'd125, 4'h2, 32'hDEAD_BEEF);
    send_data(8'h5A, 1'b1);
    send_start(64'd126, 4'h8, 32'h0102_0304);
    send_data(8'h00, 1'b1);
    send_data(8'hFF, 1'b1);
    send_start(64'd65535, 4'h9, 32'hFF00_FF00);
    send_start(64'd65536, 4'hA, 32'h00FF_00FF);
    send_data(8'hC3, 1'b1);
    send_start(64'hFFFF_FFFF_FFFF_FFFF, 4'h1, 32'h8000_0001);
    send_start(64'h8000_0000_0000_0000, 4'h2, 32'h7FFF_FFFE);
    send_start(64'd5, 4'h1, 32'hA5A5_A5A5);
    for (int i = 0; i < 5; i++) send_data(wsfb_pkg::byte_t'($urandom), 1'b1);
    send_data(8'h3C, 1'b0);

    run_phase(PH_CALM, 0, 0);
    run_phase(PH_TX_GAPS, 59, 0);
    run_phase(PH_RX_STALL, 0, 59);
    run_phase(PH_BOTH, 30, 30);

    phase        <= PH_PRESSURE;
    rx_stall_pct <= 0;
    tx_gap_pct   = 0;
    send_start(64'd40, 4'h2, $urandom);
    for (int i = 0; i < 40; i++) send_data(wsfb_pkg::byte_t'($urandom), 1'b1);
    send_start(64'd300, 4'h1, $urandom);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d frame starts and %0d payload words across five stall profiles",
             frames_sent, data_sent);
    $display("Compared %0d output words, %0d mismatches, %0d left over",
             checked_words, mismatch_count, pending_words);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
